### rtl/mqtt_pkg.sv
package mqtt_pkg;

    typedef enum logic [18:0] {
        PH_TYPE      = 19'd1 << 0,
        PH_REMLEN    = 19'd1 << 1,
        PH_SKIP      = 19'd1 << 2,
        PH_VERSION   = 19'd1 << 3,
        PH_CFLAGS    = 19'd1 << 4,
        PH_KA_HI     = 19'd1 << 5,
        PH_KA_LO     = 19'd1 << 6,
        PH_PID_HI    = 19'd1 << 7,
        PH_PID_LO    = 19'd1 << 8,
        PH_PROPLEN   = 19'd1 << 9,
        PH_PROPID    = 19'd1 << 10,
        PH_PVAL_BYTE = 19'd1 << 11,
        PH_PVAL_WORD = 19'd1 << 12,
        PH_STR_HI    = 19'd1 << 13,
        PH_STR_LO    = 19'd1 << 14,
        PH_STR_BODY  = 19'd1 << 15,
        PH_PAYLOAD   = 19'd1 << 16,
        PH_SQOS      = 19'd1 << 17,
        PH_DONE      = 19'd1 << 18
    } t_phase;

    localparam logic [3:0] KIND_CONNECT   = 4'd1;
    localparam logic [3:0] KIND_PUBLISH   = 4'd3;
    localparam logic [3:0] KIND_SUBSCRIBE = 4'd8;

    localparam logic [2:0] PC_NONE = 3'd0;
    localparam logic [2:0] PC_BYTE = 3'd1;
    localparam logic [2:0] PC_WORD = 3'd2;
    localparam logic [2:0] PC_STR  = 3'd3;
    localparam logic [2:0] PC_BIN  = 3'd4;
    localparam logic [2:0] PC_USER = 3'd5;

    localparam logic [3:0] TK_TYPE    = 4'd0;
    localparam logic [3:0] TK_REMLEN  = 4'd1;
    localparam logic [3:0] TK_VERSION = 4'd2;
    localparam logic [3:0] TK_CFLAGS  = 4'd3;
    localparam logic [3:0] TK_KALIVE  = 4'd4;
    localparam logic [3:0] TK_STRLEN  = 4'd5;
    localparam logic [3:0] TK_STRBYTE = 4'd6;
    localparam logic [3:0] TK_PKTID   = 4'd7;
    localparam logic [3:0] TK_PROPID  = 4'd8;
    localparam logic [3:0] TK_PROPVAL = 4'd9;
    localparam logic [3:0] TK_PAYLOAD = 4'd10;
    localparam logic [3:0] TK_SUBQOS  = 4'd11;
    localparam logic [3:0] TK_NONE    = 4'd12;

    localparam logic [3:0] FID_PROTO   = 4'd0;
    localparam logic [3:0] FID_CLIENT  = 4'd1;
    localparam logic [3:0] FID_WTOPIC  = 4'd2;
    localparam logic [3:0] FID_WPAY    = 4'd3;
    localparam logic [3:0] FID_USER    = 4'd4;
    localparam logic [3:0] FID_PASS    = 4'd5;
    localparam logic [3:0] FID_TOPIC   = 4'd6;
    localparam logic [3:0] FID_FILTER  = 4'd7;
    localparam logic [3:0] FID_PSTR    = 4'd8;
    localparam logic [3:0] FID_UKEY    = 4'd9;
    localparam logic [3:0] FID_UVAL    = 4'd10;
    localparam logic [3:0] FID_PBIN    = 4'd11;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_SHORT = 3'd1;
    localparam logic [2:0] ERR_TYPE  = 3'd2;
    localparam logic [2:0] ERR_PROP  = 3'd3;
    localparam logic [2:0] ERR_LEN   = 3'd4;

    // one result token
    typedef struct packed {
        logic [3:0]  kind;
        logic [3:0]  fid;
        logic [31:0] value;
        logic [2:0]  err;
        logic        pend;
    } t_token;

    // what one byte produced: up to two tokens
    typedef struct packed {
        logic   two;
        t_token first;
        t_token second;
    } t_entry;

    function automatic logic [2:0] prop_class(input logic [7:0] id);
        logic [2:0] c;
        c = PC_NONE;
        case (id)
            8'd1, 8'd23, 8'd25, 8'd36, 8'd37, 8'd40, 8'd41, 8'd42: c = PC_BYTE;
            8'd2, 8'd17, 8'd24, 8'd39: c = PC_WORD;
            8'd3, 8'd8, 8'd18, 8'd21, 8'd26, 8'd28, 8'd31: c = PC_STR;
            8'd9, 8'd22: c = PC_BIN;
            8'd38: c = PC_USER;
            default: c = PC_NONE;
        endcase
        return c;
    endfunction

endpackage

### rtl/mqtt_front.sv
module mqtt_front #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [7:0]          i_data_byte,
    input  logic                i_buffer_end,
    output logic                o_push,
    output mqtt_pkg::t_entry    o_entry,
    input  logic                i_full
);
    mqtt_pkg::t_phase r_phase, n_phase;
    logic [3:0]  r_kind, n_kind;
    logic [27:0] r_rem, n_rem;
    logic [1:0]  r_lbi, n_lbi;
    logic [27:0] r_cons, n_cons;
    logic [15:0] r_fleft, n_fleft;
    logic [7:0]  r_flags, n_flags;
    logic [7:0]  r_pleft, n_pleft;
    logic [31:0] r_acc, n_acc;
    logic [2:0]  r_pclass, n_pclass;
    logic [3:0]  r_sfield, n_sfield;

    logic        fire;
    assign o_ready = !i_full;
    assign fire    = i_valid && o_ready;

    always_comb begin
        logic [7:0]  b;
        logic        last, have, complete, in_prop, endpoint, will;
        logic [3:0]  kind, fid, f, nk;
        logic [31:0] val;
        logic [2:0]  err, pc;
        logic [15:0] fl;
        logic [4:0]  sh;
        b = i_data_byte;
        last = i_buffer_end;
        have = 1'b0; complete = 1'b0; in_prop = 1'b0; endpoint = 1'b0;
        kind = mqtt_pkg::TK_NONE; fid = 4'd0; val = 32'd0; err = mqtt_pkg::ERR_OK;
        pc = mqtt_pkg::PC_NONE; fl = 16'd0; sh = 5'd0; f = 4'd0; will = 1'b0; nk = 4'd0;
        n_phase = r_phase; n_kind = r_kind; n_rem = r_rem; n_lbi = r_lbi;
        n_cons = r_cons; n_fleft = r_fleft; n_flags = r_flags; n_pleft = r_pleft;
        n_acc = r_acc; n_pclass = r_pclass; n_sfield = r_sfield;
        o_push = 1'b0;
        o_entry = '0;

        if (r_phase == mqtt_pkg::PH_SKIP) begin
            if (last) n_phase = mqtt_pkg::PH_TYPE;
        end else begin
            if (r_phase == mqtt_pkg::PH_TYPE) begin
                have = 1'b1; kind = mqtt_pkg::TK_TYPE; val = {24'd0, b};
                nk = b[7:4];
                n_kind = nk; n_flags = {4'd0, b[3:0]};
                n_rem = '0; n_lbi = '0; n_cons = '0; n_fleft = '0; n_pleft = '0;
                n_acc = '0; n_pclass = '0; n_sfield = '0;
                if (last) err = mqtt_pkg::ERR_SHORT;
                else if (nk != mqtt_pkg::KIND_CONNECT && nk != mqtt_pkg::KIND_PUBLISH
                         && nk != mqtt_pkg::KIND_SUBSCRIBE) err = mqtt_pkg::ERR_TYPE;
                else n_phase = mqtt_pkg::PH_REMLEN;
            end else if (r_phase == mqtt_pkg::PH_REMLEN) begin
                // low seven bits first, shift by seven per length byte
                sh = 5'(7 * r_lbi);
                n_rem = r_rem + 28'({21'd0, b[6:0]} << sh);
                if (b[7]) begin
                    if ({1'b0, r_lbi} + 3'd1 >= 3'(MAX_LENGTH_BYTES)) err = mqtt_pkg::ERR_LEN;
                    else begin
                        n_lbi = r_lbi + 2'd1;
                        if (last) err = mqtt_pkg::ERR_SHORT;
                    end
                end else begin
                    have = 1'b1; kind = mqtt_pkg::TK_REMLEN; val = {4'd0, n_rem};
                    n_cons = '0;
                    if (n_rem == 28'd0 || last) err = mqtt_pkg::ERR_SHORT;
                    else if (r_kind == mqtt_pkg::KIND_CONNECT) begin
                        n_sfield = mqtt_pkg::FID_PROTO; n_phase = mqtt_pkg::PH_STR_HI;
                    end else if (r_kind == mqtt_pkg::KIND_PUBLISH) begin
                        n_sfield = mqtt_pkg::FID_TOPIC; n_phase = mqtt_pkg::PH_STR_HI;
                    end else n_phase = mqtt_pkg::PH_PID_HI;
                end
            end else begin
                n_cons = r_cons + 28'd1;
                in_prop = r_phase == mqtt_pkg::PH_PROPID || r_phase == mqtt_pkg::PH_PVAL_BYTE
                    || r_phase == mqtt_pkg::PH_PVAL_WORD
                    || ((r_phase == mqtt_pkg::PH_STR_HI || r_phase == mqtt_pkg::PH_STR_LO
                         || r_phase == mqtt_pkg::PH_STR_BODY) && r_sfield >= 4'd8);
                if (in_prop) begin
                    if (r_pleft == 8'd0) err = mqtt_pkg::ERR_LEN;
                    else n_pleft = r_pleft - 8'd1;
                end
                if (err == mqtt_pkg::ERR_OK) begin
                    // f says what follows: 14 string end, 15 next property, 2 to 5 next connect field
                    f = 4'd0;
                    case (r_phase)
                        mqtt_pkg::PH_VERSION: begin
                            have = 1'b1; kind = mqtt_pkg::TK_VERSION; val = {24'd0, b};
                            n_phase = mqtt_pkg::PH_CFLAGS;
                        end
                        mqtt_pkg::PH_CFLAGS: begin
                            have = 1'b1; kind = mqtt_pkg::TK_CFLAGS; val = {24'd0, b};
                            n_flags = b; n_phase = mqtt_pkg::PH_KA_HI;
                        end
                        mqtt_pkg::PH_KA_HI: begin
                            n_acc = {24'd0, b}; n_phase = mqtt_pkg::PH_KA_LO;
                        end
                        mqtt_pkg::PH_PID_HI: begin
                            n_acc = {24'd0, b}; n_phase = mqtt_pkg::PH_PID_LO;
                        end
                        mqtt_pkg::PH_KA_LO, mqtt_pkg::PH_PID_LO: begin
                            have = 1'b1;
                            kind = (r_phase == mqtt_pkg::PH_KA_LO) ? mqtt_pkg::TK_KALIVE
                                                                    : mqtt_pkg::TK_PKTID;
                            val = {16'd0, r_acc[7:0], b};
                            n_phase = mqtt_pkg::PH_PROPLEN;
                        end
                        mqtt_pkg::PH_PROPLEN: begin
                            n_pleft = b;
                            f = 4'd15;
                        end
                        mqtt_pkg::PH_PROPID: begin
                            have = 1'b1; kind = mqtt_pkg::TK_PROPID; val = {24'd0, b};
                            pc = mqtt_pkg::prop_class(b);
                            n_pclass = pc;
                            case (pc)
                                mqtt_pkg::PC_BYTE: n_phase = mqtt_pkg::PH_PVAL_BYTE;
                                mqtt_pkg::PC_WORD: begin
                                    n_acc = '0; n_fleft = 16'd4;
                                    n_phase = mqtt_pkg::PH_PVAL_WORD;
                                end
                                mqtt_pkg::PC_STR: begin
                                    n_sfield = mqtt_pkg::FID_PSTR;
                                    n_phase = mqtt_pkg::PH_STR_HI;
                                end
                                mqtt_pkg::PC_BIN: begin
                                    n_sfield = mqtt_pkg::FID_PBIN;
                                    n_phase = mqtt_pkg::PH_STR_HI;
                                end
                                mqtt_pkg::PC_USER: begin
                                    n_sfield = mqtt_pkg::FID_UKEY;
                                    n_phase = mqtt_pkg::PH_STR_HI;
                                end
                                default: err = mqtt_pkg::ERR_PROP;
                            endcase
                        end
                        mqtt_pkg::PH_PVAL_BYTE: begin
                            have = 1'b1; kind = mqtt_pkg::TK_PROPVAL; val = {24'd0, b};
                            f = 4'd15;
                        end
                        mqtt_pkg::PH_PVAL_WORD: begin
                            n_acc = {r_acc[23:0], b};
                            n_fleft = r_fleft - 16'd1;
                            if (n_fleft == 16'd0) begin
                                have = 1'b1; kind = mqtt_pkg::TK_PROPVAL; val = n_acc;
                                f = 4'd15;
                            end
                        end
                        mqtt_pkg::PH_STR_HI: begin
                            n_acc = {24'd0, b}; n_phase = mqtt_pkg::PH_STR_LO;
                        end
                        mqtt_pkg::PH_STR_LO: begin
                            fl = {r_acc[7:0], b};
                            n_fleft = fl;
                            have = 1'b1; kind = mqtt_pkg::TK_STRLEN; fid = r_sfield;
                            val = {16'd0, fl};
                            if (fl == 16'd0) f = 4'd14;
                            else n_phase = mqtt_pkg::PH_STR_BODY;
                        end
                        mqtt_pkg::PH_STR_BODY: begin
                            have = 1'b1; kind = mqtt_pkg::TK_STRBYTE; fid = r_sfield;
                            val = {24'd0, b};
                            n_fleft = r_fleft - 16'd1;
                            if (n_fleft == 16'd0) f = 4'd14;
                        end
                        mqtt_pkg::PH_PAYLOAD: begin
                            have = 1'b1; kind = mqtt_pkg::TK_PAYLOAD; val = {24'd0, b};
                        end
                        mqtt_pkg::PH_SQOS: begin
                            have = 1'b1; kind = mqtt_pkg::TK_SUBQOS; val = {30'd0, b[1:0]};
                            n_sfield = mqtt_pkg::FID_FILTER; n_phase = mqtt_pkg::PH_STR_HI;
                        end
                        default: err = mqtt_pkg::ERR_LEN;
                    endcase
                    // end of a string: pick what follows
                    if (f == 4'd14) begin
                        f = 4'd15;
                        case (r_sfield)
                            mqtt_pkg::FID_PROTO:  begin n_phase = mqtt_pkg::PH_VERSION; f = 4'd0; end
                            mqtt_pkg::FID_CLIENT: f = 4'd2;
                            mqtt_pkg::FID_WTOPIC: f = 4'd3;
                            mqtt_pkg::FID_WPAY:   f = 4'd4;
                            mqtt_pkg::FID_USER:   f = 4'd5;
                            mqtt_pkg::FID_PASS:   begin n_phase = mqtt_pkg::PH_DONE; f = 4'd0; end
                            mqtt_pkg::FID_TOPIC: begin
                                f = 4'd0;
                                if (r_flags[2:1] != 2'd0) n_phase = mqtt_pkg::PH_PID_HI;
                                else n_phase = mqtt_pkg::PH_PROPLEN;
                            end
                            mqtt_pkg::FID_FILTER: begin n_phase = mqtt_pkg::PH_SQOS; f = 4'd0; end
                            mqtt_pkg::FID_UKEY: begin
                                f = 4'd0; n_sfield = mqtt_pkg::FID_UVAL;
                                n_phase = mqtt_pkg::PH_STR_HI;
                            end
                            default: f = 4'd15;
                        endcase
                    end
                    // next property or the section that follows them
                    if (f == 4'd15) begin
                        if (n_pleft != 8'd0) n_phase = mqtt_pkg::PH_PROPID;
                        else if (r_kind == mqtt_pkg::KIND_CONNECT) begin
                            n_sfield = mqtt_pkg::FID_CLIENT; n_phase = mqtt_pkg::PH_STR_HI;
                        end else if (r_kind == mqtt_pkg::KIND_PUBLISH)
                            n_phase = mqtt_pkg::PH_PAYLOAD;
                        else begin
                            n_sfield = mqtt_pkg::FID_FILTER; n_phase = mqtt_pkg::PH_STR_HI;
                        end
                    end else if (f >= 4'd2 && f <= 4'd5) begin
                        will = n_flags[2];
                        if (f == 4'd2 && will) begin
                            n_sfield = mqtt_pkg::FID_WTOPIC; n_phase = mqtt_pkg::PH_STR_HI;
                        end else if (f <= 4'd3 && will) begin
                            n_sfield = mqtt_pkg::FID_WPAY; n_phase = mqtt_pkg::PH_STR_HI;
                        end else if (f <= 4'd4 && n_flags[7]) begin
                            n_sfield = mqtt_pkg::FID_USER; n_phase = mqtt_pkg::PH_STR_HI;
                        end else if (n_flags[6]) begin
                            n_sfield = mqtt_pkg::FID_PASS; n_phase = mqtt_pkg::PH_STR_HI;
                        end else n_phase = mqtt_pkg::PH_DONE;
                    end
                end
                if (err == mqtt_pkg::ERR_OK) begin
                    endpoint = n_phase == mqtt_pkg::PH_DONE || n_phase == mqtt_pkg::PH_PAYLOAD
                        || (n_phase == mqtt_pkg::PH_STR_HI && n_sfield == mqtt_pkg::FID_FILTER);
                    if (n_cons == r_rem) begin
                        if (endpoint) complete = 1'b1;
                        else err = mqtt_pkg::ERR_SHORT;
                    end else if (n_phase == mqtt_pkg::PH_DONE) err = mqtt_pkg::ERR_LEN;
                    else if (last) err = mqtt_pkg::ERR_SHORT;
                end
            end

            if (err != mqtt_pkg::ERR_OK) begin
                o_push = 1'b1;
                o_entry.two = have;
                o_entry.first = have ? '{kind, fid, val, mqtt_pkg::ERR_OK, 1'b0}
                                     : '{mqtt_pkg::TK_NONE, 4'd0, 32'd0, err, 1'b1};
                o_entry.second = '{mqtt_pkg::TK_NONE, 4'd0, 32'd0, err, 1'b1};
                n_phase = last ? mqtt_pkg::PH_TYPE : mqtt_pkg::PH_SKIP;
            end else if (complete) begin
                o_push = 1'b1;
                o_entry.first = have ? '{kind, fid, val, mqtt_pkg::ERR_OK, 1'b1}
                                     : '{mqtt_pkg::TK_NONE, 4'd0, 32'd0, mqtt_pkg::ERR_OK, 1'b1};
                n_phase = mqtt_pkg::PH_TYPE;
            end else if (have) begin
                o_push = 1'b1;
                o_entry.first = '{kind, fid, val, mqtt_pkg::ERR_OK, 1'b0};
            end
        end
        if (!fire) o_push = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= mqtt_pkg::PH_TYPE;
            r_kind <= '0; r_rem <= '0; r_lbi <= '0; r_cons <= '0; r_fleft <= '0;
            r_flags <= '0; r_pleft <= '0; r_acc <= '0; r_pclass <= '0; r_sfield <= '0;
        end else if (fire) begin
            r_phase <= n_phase;
            r_kind <= n_kind; r_rem <= n_rem; r_lbi <= n_lbi; r_cons <= n_cons;
            r_fleft <= n_fleft; r_flags <= n_flags; r_pleft <= n_pleft; r_acc <= n_acc;
            r_pclass <= n_pclass; r_sfield <= n_sfield;
        end
    end

`ifndef SYNTHESIS
    a_no_push_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> fire) else $error("push without accepted byte");
    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == mqtt_pkg::PH_SKIP) |-> !o_push) else $error("output while skipping");
    a_lbi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_lbi} < 3'(MAX_LENGTH_BYTES))) else $error("length index overflow");
`endif
endmodule

### rtl/mqtt_queue.sv
module mqtt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  mqtt_pkg::t_entry i_entry,
    output logic             o_full,
    output logic             o_valid,
    output mqtt_pkg::t_entry o_entry,
    input  logic             i_pop
);
    // two entry circular queue
    mqtt_pkg::t_entry r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt == 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_entry = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_entry;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= !r_wp;
            if (i_pop) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'd2) else $error("queue count out of range");
`endif
endmodule

### rtl/mqtt_back.sv
module mqtt_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  mqtt_pkg::t_entry i_entry,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output mqtt_pkg::t_token o_token
);
    // r_half: first token of a two token entry already delivered
    logic r_half;
    logic take;

    assign o_valid = i_valid;
    assign o_token = r_half ? i_entry.second : i_entry.first;
    assign take    = i_valid && i_ready;
    assign o_pop   = take && (r_half || !i_entry.two);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_half <= 1'b0;
        else if (take) r_half <= !r_half && i_entry.two;
    end

`ifndef SYNTHESIS
    a_half_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_half |-> i_valid && i_entry.two) else $error("second half lost");
    a_err_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_token.err != mqtt_pkg::ERR_OK) |-> o_token.pend)
        else $error("error without packet end");
`endif
endmodule

### rtl/mqtt_packet_stream_parser.sv
// a byte's tokens are registered in the queue when the byte is accepted and offered from its head
// throughput: one byte per cycle while the queue is not full; a byte giving two tokens sends them in turn
// the two entry queue between the byte decoder and the token sender sets the stall depth
// reset: synchronous active low; parser returns to the fixed header byte, queue empties
module mqtt_packet_stream_parser #(
    parameter int MAX_LENGTH_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_buffer_end,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_token_kind,
    output logic [3:0]  o_field_id,
    output logic [31:0] o_token_value,
    output logic [2:0]  o_error_code,
    output logic        o_packet_end
);
    // decoder to queue
    logic             push, full;
    mqtt_pkg::t_entry f_entry;
    // queue to sender
    logic             q_valid, pop;
    mqtt_pkg::t_entry q_entry;
    mqtt_pkg::t_token tok;

    // front: walks the packet fields, one byte per cycle while the queue is not full
    mqtt_front #(.MAX_LENGTH_BYTES(MAX_LENGTH_BYTES)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready,
        .i_data_byte, .i_buffer_end,
        .o_push(push), .o_entry(f_entry), .i_full(full)
    );

    // short queue decouples decoder from the output stall
    mqtt_queue u_queue (
        .i_clk, .i_rst_n,
        .i_push(push), .i_entry(f_entry), .o_full(full),
        .o_valid(q_valid), .o_entry(q_entry), .i_pop(pop)
    );

    // back: serialises one or two tokens per entry
    mqtt_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .i_entry(q_entry), .o_pop(pop),
        .o_valid, .i_ready, .o_token(tok)
    );

    assign o_token_kind  = tok.kind;
    assign o_field_id    = tok.fid;
    assign o_token_value = tok.value;
    assign o_error_code  = tok.err;
    assign o_packet_end  = tok.pend;
endmodule

### tb/sv/mqtt_packet_stream_parser_test.sv
module mqtt_packet_stream_parser_test;

    localparam int MAX_LEN_BYTES = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int BYTE_TARGET   = 1550;

    // one byte waiting to be offered, with an optional hold-off until the parser drains
    typedef struct {
        logic [7:0] b;
        logic       e;
        logic       hold;
    } t_feed;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_buffer_end = 1'b0;
    logic        i_ready = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic [3:0]  o_token_kind;
    logic [3:0]  o_field_id;
    logic [31:0] o_token_value;
    logic [2:0]  o_error_code;
    logic        o_packet_end;

    mqtt_packet_stream_parser #(.MAX_LENGTH_BYTES(MAX_LEN_BYTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_buffer_end(i_buffer_end),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_token_kind(o_token_kind), .o_field_id(o_field_id),
        .o_token_value(o_token_value), .o_error_code(o_error_code),
        .o_packet_end(o_packet_end)
    );

    always #5 i_clk = ~i_clk;

    t_feed            byte_feed[$];
    mqtt_pkg::t_token due_tokens[$];
    logic [7:0] pkt[$];
    logic [7:0] tmp[$];

    int errors = 0;
    int cycles = 0;
    int bytes_taken = 0;
    int tokens_seen = 0;
    int err_seen[5] = '{0, 0, 0, 0, 0};
    int packets_done = 0;
    bit byte_taken = 0;

    // parser model state
    mqtt_pkg::t_phase ph = mqtt_pkg::PH_TYPE;
    logic [3:0]  pk = '0;
    logic [27:0] rem = '0;
    logic [1:0]  lidx = '0;
    logic [27:0] used = '0;
    logic [15:0] fleft = '0;
    logic [7:0]  flg = '0;
    logic [7:0]  pleft = '0;
    logic [31:0] acc = '0;
    logic [2:0]  pcls = '0;
    logic [3:0]  sfield = '0;

    // property id to value class
    function automatic logic [2:0] class_of_prop(input logic [7:0] id);
        case (id)
            8'd1, 8'd23, 8'd25, 8'd36, 8'd37, 8'd40, 8'd41, 8'd42: return mqtt_pkg::PC_BYTE;
            8'd2, 8'd17, 8'd24, 8'd39: return mqtt_pkg::PC_WORD;
            8'd3, 8'd8, 8'd18, 8'd21, 8'd26, 8'd28, 8'd31: return mqtt_pkg::PC_STR;
            8'd9, 8'd22: return mqtt_pkg::PC_BIN;
            8'd38: return mqtt_pkg::PC_USER;
            default: return mqtt_pkg::PC_NONE;
        endcase
    endfunction

    function void begin_string(input logic [3:0] f);
        sfield = f;
        ph = mqtt_pkg::PH_STR_HI;
    endfunction

    function void leave_props();
        if (pk == mqtt_pkg::KIND_CONNECT) begin_string(mqtt_pkg::FID_CLIENT);
        else if (pk == mqtt_pkg::KIND_PUBLISH) ph = mqtt_pkg::PH_PAYLOAD;
        else begin_string(mqtt_pkg::FID_FILTER);
    endfunction

    function void next_prop();
        if (pleft != 0) ph = mqtt_pkg::PH_PROPID;
        else leave_props();
    endfunction

    // optional connect strings, chosen by the connect flags
    function void connect_next(input int f);
        bit will;
        will = flg[2];
        if (f == 2 && will) begin_string(mqtt_pkg::FID_WTOPIC);
        else if (f == 3 && will) begin_string(mqtt_pkg::FID_WPAY);
        else if (f <= 4 && flg[7]) begin_string(mqtt_pkg::FID_USER);
        else if (f <= 5 && flg[6]) begin_string(mqtt_pkg::FID_PASS);
        else ph = mqtt_pkg::PH_DONE;
    endfunction

    function void string_done();
        case (sfield)
            mqtt_pkg::FID_PROTO:  ph = mqtt_pkg::PH_VERSION;
            mqtt_pkg::FID_CLIENT: connect_next(2);
            mqtt_pkg::FID_WTOPIC: connect_next(3);
            mqtt_pkg::FID_WPAY:   connect_next(4);
            mqtt_pkg::FID_USER:   connect_next(5);
            mqtt_pkg::FID_PASS:   ph = mqtt_pkg::PH_DONE;
            mqtt_pkg::FID_TOPIC: begin
                if (flg[2:1] != 2'b00) ph = mqtt_pkg::PH_PID_HI;
                else ph = mqtt_pkg::PH_PROPLEN;
            end
            mqtt_pkg::FID_FILTER: ph = mqtt_pkg::PH_SQOS;
            mqtt_pkg::FID_UKEY:   begin_string(mqtt_pkg::FID_UVAL);
            default:              next_prop();
        endcase
    endfunction

    function void push_token(input logic [3:0] k, input logic [3:0] f, input logic [31:0] v,
                             input logic [2:0] e, input logic pe);
        mqtt_pkg::t_token t;
        t.kind = k; t.fid = f; t.value = v; t.err = e; t.pend = pe;
        due_tokens = {due_tokens, t};
    endfunction

    // advance the parser model by one accepted byte and queue its tokens
    function void decode_byte(input logic [7:0] b, input logic last);
        bit have, complete, in_prop, endpoint;
        logic [3:0]  kind, fid;
        logic [31:0] val;
        logic [2:0]  err;
        have = 0; complete = 0;
        kind = mqtt_pkg::TK_NONE; fid = '0; val = '0; err = mqtt_pkg::ERR_OK;
        if (ph == mqtt_pkg::PH_SKIP) begin
            if (last) ph = mqtt_pkg::PH_TYPE;
            return;
        end
        if (ph == mqtt_pkg::PH_TYPE) begin
            have = 1; kind = mqtt_pkg::TK_TYPE; val = {24'h0, b};
            pk = b[7:4]; flg = {4'h0, b[3:0]};
            rem = '0; lidx = '0; used = '0; fleft = '0; pleft = '0;
            acc = '0; pcls = '0; sfield = '0;
            if (last) err = mqtt_pkg::ERR_SHORT;
            else if (pk != mqtt_pkg::KIND_CONNECT && pk != mqtt_pkg::KIND_PUBLISH
                     && pk != mqtt_pkg::KIND_SUBSCRIBE)
                err = mqtt_pkg::ERR_TYPE;
            else ph = mqtt_pkg::PH_REMLEN;
        end else if (ph == mqtt_pkg::PH_REMLEN) begin
            rem = rem + (28'(b[6:0]) << (7 * lidx));
            if (b[7]) begin
                if (int'(lidx) + 1 >= MAX_LEN_BYTES) err = mqtt_pkg::ERR_LEN;
                else begin
                    lidx = lidx + 2'd1;
                    if (last) err = mqtt_pkg::ERR_SHORT;
                end
            end else begin
                have = 1; kind = mqtt_pkg::TK_REMLEN; val = 32'(rem);
                used = '0;
                if (rem == 0 || last) err = mqtt_pkg::ERR_SHORT;
                else if (pk == mqtt_pkg::KIND_CONNECT) begin_string(mqtt_pkg::FID_PROTO);
                else if (pk == mqtt_pkg::KIND_PUBLISH) begin_string(mqtt_pkg::FID_TOPIC);
                else ph = mqtt_pkg::PH_PID_HI;
            end
        end else begin
            used = used + 28'd1;
            in_prop = ph == mqtt_pkg::PH_PROPID || ph == mqtt_pkg::PH_PVAL_BYTE
                      || ph == mqtt_pkg::PH_PVAL_WORD
                      || ((ph == mqtt_pkg::PH_STR_HI || ph == mqtt_pkg::PH_STR_LO
                           || ph == mqtt_pkg::PH_STR_BODY) && sfield >= mqtt_pkg::FID_PSTR);
            if (in_prop) begin
                if (pleft == 0) err = mqtt_pkg::ERR_LEN;
                else pleft = pleft - 8'd1;
            end
            if (err == mqtt_pkg::ERR_OK) begin
                case (ph)
                    mqtt_pkg::PH_VERSION: begin
                        have = 1; kind = mqtt_pkg::TK_VERSION; val = {24'h0, b};
                        ph = mqtt_pkg::PH_CFLAGS;
                    end
                    mqtt_pkg::PH_CFLAGS: begin
                        have = 1; kind = mqtt_pkg::TK_CFLAGS; val = {24'h0, b}; flg = b;
                        ph = mqtt_pkg::PH_KA_HI;
                    end
                    mqtt_pkg::PH_KA_HI: begin acc = {24'h0, b}; ph = mqtt_pkg::PH_KA_LO; end
                    mqtt_pkg::PH_PID_HI: begin acc = {24'h0, b}; ph = mqtt_pkg::PH_PID_LO; end
                    mqtt_pkg::PH_KA_LO, mqtt_pkg::PH_PID_LO: begin
                        have = 1;
                        kind = (ph == mqtt_pkg::PH_KA_LO) ? mqtt_pkg::TK_KALIVE
                                                          : mqtt_pkg::TK_PKTID;
                        val = {16'h0, acc[7:0], b};
                        ph = mqtt_pkg::PH_PROPLEN;
                    end
                    mqtt_pkg::PH_PROPLEN: begin pleft = b; next_prop(); end
                    mqtt_pkg::PH_PROPID: begin
                        have = 1; kind = mqtt_pkg::TK_PROPID; val = {24'h0, b};
                        pcls = class_of_prop(b);
                        if (pcls == mqtt_pkg::PC_BYTE) ph = mqtt_pkg::PH_PVAL_BYTE;
                        else if (pcls == mqtt_pkg::PC_WORD) begin
                            acc = '0; fleft = 16'd4; ph = mqtt_pkg::PH_PVAL_WORD;
                        end
                        else if (pcls == mqtt_pkg::PC_STR) begin_string(mqtt_pkg::FID_PSTR);
                        else if (pcls == mqtt_pkg::PC_BIN) begin_string(mqtt_pkg::FID_PBIN);
                        else if (pcls == mqtt_pkg::PC_USER) begin_string(mqtt_pkg::FID_UKEY);
                        else err = mqtt_pkg::ERR_PROP;
                    end
                    mqtt_pkg::PH_PVAL_BYTE: begin
                        have = 1; kind = mqtt_pkg::TK_PROPVAL; val = {24'h0, b}; next_prop();
                    end
                    mqtt_pkg::PH_PVAL_WORD: begin
                        acc = {acc[23:0], b};
                        fleft = fleft - 16'd1;
                        if (fleft == 0) begin
                            have = 1; kind = mqtt_pkg::TK_PROPVAL; val = acc; next_prop();
                        end
                    end
                    mqtt_pkg::PH_STR_HI: begin acc = {24'h0, b}; ph = mqtt_pkg::PH_STR_LO; end
                    mqtt_pkg::PH_STR_LO: begin
                        fleft = {acc[7:0], b};
                        have = 1; kind = mqtt_pkg::TK_STRLEN; fid = sfield;
                        val = {16'h0, fleft};
                        if (fleft == 0) string_done();
                        else ph = mqtt_pkg::PH_STR_BODY;
                    end
                    mqtt_pkg::PH_STR_BODY: begin
                        have = 1; kind = mqtt_pkg::TK_STRBYTE; fid = sfield; val = {24'h0, b};
                        fleft = fleft - 16'd1;
                        if (fleft == 0) string_done();
                    end
                    mqtt_pkg::PH_PAYLOAD: begin
                        have = 1; kind = mqtt_pkg::TK_PAYLOAD; val = {24'h0, b};
                    end
                    mqtt_pkg::PH_SQOS: begin
                        have = 1; kind = mqtt_pkg::TK_SUBQOS; val = {30'h0, b[1:0]};
                        begin_string(mqtt_pkg::FID_FILTER);
                    end
                    default: err = mqtt_pkg::ERR_LEN;
                endcase
            end
            if (err == mqtt_pkg::ERR_OK) begin
                endpoint = ph == mqtt_pkg::PH_DONE || ph == mqtt_pkg::PH_PAYLOAD ||
                           (ph == mqtt_pkg::PH_STR_HI && sfield == mqtt_pkg::FID_FILTER);
                if (used == rem) begin
                    if (endpoint) complete = 1;
                    else err = mqtt_pkg::ERR_SHORT;
                end else if (ph == mqtt_pkg::PH_DONE) err = mqtt_pkg::ERR_LEN;
                else if (last) err = mqtt_pkg::ERR_SHORT;
            end
        end
        if (err != mqtt_pkg::ERR_OK) begin
            if (have) push_token(kind, fid, val, mqtt_pkg::ERR_OK, 1'b0);
            push_token(mqtt_pkg::TK_NONE, '0, '0, err, 1'b1);
            ph = last ? mqtt_pkg::PH_TYPE : mqtt_pkg::PH_SKIP;
        end else if (complete) begin
            if (have) push_token(kind, fid, val, mqtt_pkg::ERR_OK, 1'b1);
            else push_token(mqtt_pkg::TK_NONE, '0, '0, mqtt_pkg::ERR_OK, 1'b1);
            ph = mqtt_pkg::PH_TYPE;
        end else if (have) begin
            push_token(kind, fid, val, mqtt_pkg::ERR_OK, 1'b0);
        end
    endfunction

    // ---------------- stimulus building ----------------

    function void feed(input logic [7:0] b, input logic e, input logic hold = 1'b0);
        t_feed f;
        f.b = b; f.e = e; f.hold = hold;
        byte_feed = {byte_feed, f};
    endfunction

    function automatic void add_string(ref logic [7:0] q[$], input int n);
        q = {q, 8'(n >> 8)};
        q = {q, 8'(n)};
        repeat (n) q = {q, 8'($urandom)};
    endfunction

    // property section: one length byte, then id/value pairs
    function void add_props();
        int budget;
        logic [7:0] ids[$];
        logic [7:0] id;
        tmp.delete();
        ids = '{1, 2, 3, 8, 9, 17, 18, 21, 22, 23, 24, 25, 26, 28, 31, 36, 37, 38, 39,
                40, 41, 42};
        budget = $urandom_range(0, 3);
        repeat (budget) begin
            id = ids[$urandom_range(0, ids.size() - 1)];
            tmp = {tmp, id};
            case (class_of_prop(id))
                mqtt_pkg::PC_BYTE: tmp = {tmp, 8'($urandom)};
                mqtt_pkg::PC_WORD: repeat (4) tmp = {tmp, 8'($urandom)};
                mqtt_pkg::PC_USER: begin
                    add_string(tmp, $urandom_range(0, 3));
                    add_string(tmp, $urandom_range(0, 3));
                end
                default: add_string(tmp, $urandom_range(0, 4));
            endcase
        end
        pkt = {pkt, 8'(tmp.size())};
        foreach (tmp[i]) pkt = {pkt, tmp[i]};
    endfunction

    // builds one well-formed packet body in pkt, returns the fixed header byte
    function logic [7:0] build_body();
        int sel;
        logic [7:0] cf, hdr;
        pkt.delete();
        sel = $urandom_range(0, 2);
        if (sel == 0) begin
            cf = 8'($urandom);
            hdr = {mqtt_pkg::KIND_CONNECT, 4'($urandom)};
            add_string(pkt, $urandom_range(0, 4));
            pkt = {pkt, 8'($urandom)};
            pkt = {pkt, cf};
            pkt = {pkt, 8'($urandom)};
            pkt = {pkt, 8'($urandom)};
            add_props();
            add_string(pkt, $urandom_range(0, 4));
            if (cf[2]) begin
                add_string(pkt, $urandom_range(0, 3));
                add_string(pkt, $urandom_range(0, 3));
            end
            if (cf[7]) add_string(pkt, $urandom_range(0, 3));
            if (cf[6]) add_string(pkt, $urandom_range(0, 3));
        end else if (sel == 1) begin
            hdr = {mqtt_pkg::KIND_PUBLISH, 4'($urandom)};
            add_string(pkt, $urandom_range(0, 4));
            if (hdr[2:1] != 2'b00) begin
                pkt = {pkt, 8'($urandom)};
                pkt = {pkt, 8'($urandom)};
            end
            add_props();
            // an occasional long payload can give a two-byte remaining length
            repeat (($urandom_range(0, 49) == 0) ? $urandom_range(120, 200)
                                                 : $urandom_range(0, 6))
                pkt = {pkt, 8'($urandom)};
        end else begin
            hdr = {mqtt_pkg::KIND_SUBSCRIBE, 4'($urandom)};
            pkt = {pkt, 8'($urandom)};
            pkt = {pkt, 8'($urandom)};
            add_props();
            repeat ($urandom_range(0, 3)) begin
                add_string(pkt, $urandom_range(0, 4));
                pkt = {pkt, 8'($urandom)};
            end
        end
        return hdr;
    endfunction

    // full packet in tmp with a header, then well-formed, truncated or corrupted
    function void feed_packet();
        logic [7:0] hdr;
        int n, mode, cut;
        hdr = build_body();
        n = pkt.size();
        tmp.delete();
        tmp = {tmp, hdr};
        do begin
            tmp = {tmp, {(n > 127), 7'(n)}};
            n = n >> 7;
        end while (n != 0);
        foreach (pkt[i]) tmp = {tmp, pkt[i]};
        mode = $urandom_range(0, 99);
        if (mode >= 70 && mode < 80) begin
            // buffer ends early
            cut = $urandom_range(1, tmp.size() - 1);
            while (tmp.size() > cut) void'(tmp.pop_back());
        end else if (mode >= 80 && mode < 90) begin
            tmp[$urandom_range(0, tmp.size() - 1)] = 8'($urandom);
        end
        foreach (tmp[i])
            feed(tmp[i], (i == tmp.size() - 1) ? ($urandom_range(0, 9) != 0)
                         : (mode >= 90 && $urandom_range(0, 29) == 0));
        if ($urandom_range(0, 19) == 0) begin
            // line noise
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++)
                feed(8'($urandom), (i == n - 1) || $urandom_range(0, 3) == 0);
        end
    endfunction

    function int pick_gap(input bit quiet);
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at cycle %0d: %s got %0h want %0h", cycles, what, got, want);
        errors++;
    endtask

    // ---------------- request driver ----------------
    int  send_gap = 0;
    bit  send_quiet = 0;
    int  send_count = 0;

    always @(negedge i_clk) begin
        logic nv;
        t_feed f;
        if (i_rst_n) begin
            nv = i_valid;
            if (!i_valid || byte_taken) begin
                byte_taken = 0;
                nv = 0;
                if (send_gap > 0) send_gap--;
                else if (byte_feed.size() != 0 &&
                         !(byte_feed[0].hold && due_tokens.size() != 0)) begin
                    f = byte_feed.pop_front();
                    i_data_byte <= f.b;
                    i_buffer_end <= f.e;
                    nv = 1;
                    send_count++;
                    if (send_count % 200 == 0) send_quiet = !send_quiet;
                    send_gap = pick_gap(send_quiet);
                end
            end
            i_valid <= nv;
        end
    end

    // ---------------- token receiver stalls ----------------
    int  stall_left = 0;
    bit  recv_quiet = 0;

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
            if ($urandom_range(0, 299) == 0) recv_quiet = !recv_quiet;
            stall_left = pick_gap(recv_quiet);
        end
    end

    // ---------------- monitor: predict and compare ----------------
    always @(posedge i_clk) begin
        mqtt_pkg::t_token want;
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d tokens still due", cycles,
                     due_tokens.size());
            $display("mqtt_packet_stream_parser_test: errors");
            $finish;
        end else if (i_rst_n) begin
            if (o_valid && i_ready) begin
                tokens_seen++;
                if (o_error_code <= mqtt_pkg::ERR_LEN) err_seen[o_error_code]++;
                if (o_packet_end && o_error_code == mqtt_pkg::ERR_OK) packets_done++;
                if (due_tokens.size() == 0) begin
                    report_mismatch("unexpected token kind", 32'(o_token_kind),
                                    32'(mqtt_pkg::TK_NONE));
                end else begin
                    want = due_tokens.pop_front();
                    if (o_token_kind !== want.kind)
                        report_mismatch("token_kind", 32'(o_token_kind), 32'(want.kind));
                    if (o_field_id !== want.fid)
                        report_mismatch("field_id", 32'(o_field_id), 32'(want.fid));
                    if (o_token_value !== want.value)
                        report_mismatch("token_value", o_token_value, want.value);
                    if (o_error_code !== want.err)
                        report_mismatch("error_code", 32'(o_error_code), 32'(want.err));
                    if (o_packet_end !== want.pend)
                        report_mismatch("packet_end", 32'(o_packet_end), 32'(want.pend));
                end
            end
            if (i_valid && o_ready) begin
                decode_byte(i_data_byte, i_buffer_end);
                bytes_taken++;
                byte_taken = 1;
            end
        end
    end

    // ---------------- sequence ----------------
    initial begin
        // type byte on its own ends the buffer
        feed(8'h10, 1'b1);
        // unsupported type, rest dropped up to the buffer end
        feed(8'h20, 1'b0); feed(8'h55, 1'b0); feed(8'h66, 1'b1);
        // length still continuing on its last allowed byte
        feed(8'h30, 1'b0); feed(8'hFF, 1'b0); feed(8'hFF, 1'b0); feed(8'hFF, 1'b0);
        feed(8'hFF, 1'b0); feed(8'h00, 1'b1);
        // zero remaining length
        feed(8'h30, 1'b0); feed(8'h00, 1'b0); feed(8'h00, 1'b1);
        // largest remaining length, buffer ends right after it
        feed(8'h32, 1'b0); feed(8'hFF, 1'b0); feed(8'hFF, 1'b0); feed(8'hFF, 1'b0);
        feed(8'h7F, 1'b1);
        // subscribe with an unknown property id
        feed(8'h82, 1'b0); feed(8'h04, 1'b0); feed(8'h00, 1'b0); feed(8'h01, 1'b0);
        feed(8'h01, 1'b0); feed(8'h2F, 1'b1);
        // well-formed publish, sent only after everything so far has drained
        feed(8'h30, 1'b0, 1'b1); feed(8'h03, 1'b0); feed(8'h00, 1'b0);
        feed(8'h00, 1'b0); feed(8'h00, 1'b1);
        while (byte_feed.size() < BYTE_TARGET) begin
            feed_packet();
            if ($urandom_range(0, 59) == 0) byte_feed[byte_feed.size() - 1].hold = 1'b1;
        end

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (byte_feed.size() != 0 || i_valid || due_tokens.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (due_tokens.size() != 0) begin
            $display("%0d tokens never arrived", due_tokens.size());
            errors++;
        end

        $display("%0d bytes in, %0d tokens out, %0d packets parsed whole", bytes_taken,
                 tokens_seen, packets_done);
        $display("errors flagged: short %0d, type %0d, property %0d, length %0d",
                 err_seen[mqtt_pkg::ERR_SHORT], err_seen[mqtt_pkg::ERR_TYPE],
                 err_seen[mqtt_pkg::ERR_PROP], err_seen[mqtt_pkg::ERR_LEN]);
        if (errors == 0) begin
            $display("mqtt_packet_stream_parser_test: clean");
        end else begin
            $display("mqtt_packet_stream_parser_test: errors");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/mqtt_pkg.sv
rtl/mqtt_front.sv
rtl/mqtt_queue.sv
rtl/mqtt_back.sv
rtl/mqtt_packet_stream_parser.sv
tb/sv/mqtt_packet_stream_parser_test.sv
